[src/ljpf_pkg.sv]
// Shared types and constants of the Lennard-Jones pair force unit.
`timescale 1ns / 1ps
package ljpf_pkg;

	localparam int COORD_W = 32;
	localparam int FRAC_W  = 16;
	localparam int REG_W   = 31;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;

	localparam logic [REG_W-1:0] BOX_RESET = REG_W'(20) << FRAC_W;
	localparam logic [REG_W-1:0] EPS_RESET = REG_W'(1) << FRAC_W;

	typedef enum logic [0:0] {
		REG_BOX_LENGTH = 1'b0,
		REG_WELL_DEPTH = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_BEYOND     = 2'd0,
		ST_APPLIED    = 2'd1,
		ST_CAPPED     = 2'd2,
		ST_COINCIDENT = 2'd3
	} pair_status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_a_x;
		logic signed [COORD_W-1:0] pos_a_y;
		logic signed [COORD_W-1:0] pos_a_z;
		logic signed [COORD_W-1:0] pos_b_x;
		logic signed [COORD_W-1:0] pos_b_y;
		logic signed [COORD_W-1:0] pos_b_z;
	} pair_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] force_x;
		logic signed [COORD_W-1:0] force_y;
		logic signed [COORD_W-1:0] force_z;
		pair_status_t              pair_status;
	} pair_out_t;

endpackage

[src/lennard_jones_pair_force.sv]
// Top level of the Lennard-Jones pair force unit: config registers and force pipeline.
//
//   channel  | signals                                   | direction | moves
//   ---------+-------------------------------------------+-----------+--------------------
//   req      | req_valid, req_ready, req                 | in        | one bead pair
//   rsp      | rsp_valid, rsp_ready, rsp                 | out       | force and status
//   apb      | psel, penable, pwrite, paddr, pwdata, ... | in/out    | register access
//
// One transfer is taken every cycle unless rsp stalls. The depth is set mostly by
// three pipelined dividers with one quotient bit per stage: the box fold
// (33 stages), the ratio 4/rr (35 stages) and the coefficient divide by rr
// (54 stages). All stages move together on one advance strobe,
// so a stall on rsp freezes the whole pipe and holds every item in place.
// arst_n clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
module lennard_jones_pair_force (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  ljpf_pkg::pair_in_t                  req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output ljpf_pkg::pair_out_t                 rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ljpf_pkg::APB_AW-1:0]         paddr,
	input  logic [ljpf_pkg::APB_DW-1:0]         pwdata,
	output logic [ljpf_pkg::APB_DW-1:0]         prdata,
	output logic                                pready
);

	localparam int CW   = ljpf_pkg::COORD_W;
	localparam int F    = ljpf_pkg::FRAC_W;
	localparam int LW   = ljpf_pkg::REG_W;
	localparam int MW   = CW + 1;          // magnitude of a - b
	localparam int DW   = LW - 1;          // folded magnitude, at most half the box
	localparam int SQW  = 2 * DW;
	localparam int RRW  = SQW + 2;         // sum of three squares
	localparam int RQW  = F + 5;           // rr in QF, inside the cutoff
	localparam int RNW  = 2 * F + 3;       // dividend 4 << 2F
	localparam int RTW  = F + 2;           // ratio, at most 2.0
	localparam int R2W  = F + 3;
	localparam int R6W  = F + 4;
	localparam int R6CW = F + 2;           // r6 after the cap at 3.0
	localparam int SW   = F + 4;
	localparam int TW   = F + 3;           // |t| at most 6.0
	localparam int EW   = LW + TW;
	localparam int NW   = EW + 4;          // 12 * eps * |t|
	localparam int H    = (NW + 1) / 2;
	localparam int HW   = NW - H;
	localparam int PW   = NW + DW;
	localparam int RSW  = RQW + 5 + 3 * DW;
	localparam int CSW  = 7 + 3 * DW;

	localparam logic [RRW-1:0]  CUTOFF_RR = RRW'(25) << (2 * F);
	localparam logic [RQW-1:0]  CLAMP_RQ  = RQW'(2) << F;
	localparam logic [RTW-1:0]  RATIO_MAX = RTW'(2) << F;
	localparam logic [R6W-1:0]  R6_CAP    = R6W'(3) << F;
	localparam logic [RNW-1:0]  RATIO_NUM = RNW'(1) << (2 * F + 2);
	localparam logic [63:0]     POS_LIM   = (64'(1) << (CW - 1)) - 64'(1);
	localparam logic [63:0]     NEG_LIM   = 64'(1) << (CW - 1);

	// ---------------- configuration ----------------
	logic [LW-1:0] box_q;
	logic [LW-1:0] eps_q;
	logic [LW-1:0] len;
	ljpf_pkg::reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = ljpf_pkg::reg_idx_t'(paddr[ljpf_pkg::APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= ljpf_pkg::BOX_RESET;
			eps_q <= ljpf_pkg::EPS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				ljpf_pkg::REG_BOX_LENGTH: box_q <= pwdata[LW-1:0];
				ljpf_pkg::REG_WELL_DEPTH: eps_q <= pwdata[LW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ljpf_pkg::REG_BOX_LENGTH: prdata = ljpf_pkg::APB_DW'(box_q);
			ljpf_pkg::REG_WELL_DEPTH: prdata = ljpf_pkg::APB_DW'(eps_q);
			default:                  prdata = '0;
		endcase
	end

	// a zero box acts as one lsb
	assign len = (box_q == '0) ? LW'(1) : box_q;

	// ---------------- pipeline advance ----------------
	logic adv;
	logic rsp_valid_q;

	// the whole pipe moves when the output register is free or being drained
	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = rsp_valid_q;

	// ---------------- s1: displacement magnitude and sign ----------------
	logic signed [CW-1:0] pa [3];
	logic signed [CW-1:0] pb [3];
	logic                 v_s1;
	logic [MW-1:0]        m_s1   [3];
	logic                 neg_s1 [3];

	assign pa[0] = req.pos_a_x;
	assign pa[1] = req.pos_a_y;
	assign pa[2] = req.pos_a_z;
	assign pb[0] = req.pos_b_x;
	assign pb[1] = req.pos_b_y;
	assign pb[2] = req.pos_b_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [MW-1:0] d;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d         = MW'(pa[i]) - MW'(pb[i]);
				neg_s1[i] <= d[MW-1];
				m_s1[i]   <= d[MW-1] ? MW'(-d) : MW'(d);
			end
		end
	end

	// ---------------- minimum-image fold: |d| mod L ----------------
	logic [LW-1:0] rem_f  [3];
	logic          neg_f  [3];
	logic          v_f    [3];
	logic [MW-1:0] quo_f  [3];

	for (genvar i = 0; i < 3; i++) begin : g_fold
		ljpf_div #(
			.NUM_W  (MW),
			.DEN_W  (LW),
			.SIDE_W (1)
		) u_fold (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (v_s1),
			.num       (m_s1[i]),
			.den       (len),
			.side_in   (neg_s1[i]),
			.out_valid (v_f[i]),
			.quo       (quo_f[i]),
			.rem       (rem_f[i]),
			.side_out  (neg_f[i])
		);
	end

	// ---------------- s2: round to nearest image ----------------
	logic          v_s2;
	logic [DW-1:0] dmag_s2 [3];
	logic          dneg_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_f[0] && v_f[1] && v_f[2];
		end
	end

	always_ff @(posedge clk) begin
		logic flip;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				// remainder at or past half the box: take the image on the other side
				flip       = ({rem_f[i], 1'b0} >= {1'b0, len}) && (quo_f[i] == quo_f[i]);
				dmag_s2[i] <= flip ? DW'(len - rem_f[i]) : DW'(rem_f[i]);
				dneg_s2[i] <= neg_f[i] ^ flip;
			end
		end
	end

	// ---------------- s3: squares ----------------
	logic           v_s3;
	logic [SQW-1:0] sq_s3   [3];
	logic [DW-1:0]  dmag_s3 [3];
	logic           dneg_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i]   <= SQW'(dmag_s2[i]) * SQW'(dmag_s2[i]);
				dmag_s3[i] <= dmag_s2[i];
				dneg_s3[i] <= dneg_s2[i];
			end
		end
	end

	// ---------------- s4: distance, cutoff and coincidence ----------------
	logic           v_s4;
	logic [RQW-1:0] rq_s4;
	logic           far_s4;
	logic           coin_s4;
	logic [DW-1:0]  dmag_s4 [3];
	logic           dneg_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic [RRW-1:0] rr2;
		logic [RQW-1:0] rq;
		if (adv) begin
			rr2     = RRW'(sq_s3[0]) + RRW'(sq_s3[1]) + RRW'(sq_s3[2]);
			rq      = rr2[F +: RQW];
			far_s4  <= (rr2 >= CUTOFF_RR);
			coin_s4 <= (rr2 == '0);
			// floor rr at one lsb for the divisions
			rq_s4   <= (rq == '0) ? RQW'(1) : rq;
			for (int i = 0; i < 3; i++) begin
				dmag_s4[i] <= dmag_s3[i];
				dneg_s4[i] <= dneg_s3[i];
			end
		end
	end

	// ---------------- ratio = 4 / rr ----------------
	logic [RSW-1:0] rside_in;
	logic [RSW-1:0] rside_out;
	logic [RNW-1:0] ratio_quo;
	logic [RQW-1:0] ratio_rem;
	logic           v_rd;

	assign rside_in = {rq_s4, far_s4, coin_s4,
		dneg_s4[2], dneg_s4[1], dneg_s4[0],
		dmag_s4[2], dmag_s4[1], dmag_s4[0]};

	ljpf_div #(
		.NUM_W  (RNW),
		.DEN_W  (RQW),
		.SIDE_W (RSW)
	) u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s4),
		.num       (RATIO_NUM),
		.den       (rq_s4),
		.side_in   (rside_in),
		.out_valid (v_rd),
		.quo       (ratio_quo),
		.rem       (ratio_rem),
		.side_out  (rside_out)
	);

	// ---------------- s5: clamp ratio at 2.0 ----------------
	logic           v_s5;
	logic [RTW-1:0] ratio_s5;
	logic [RSW-1:0] car_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_rd;
		end
	end

	always_ff @(posedge clk) begin
		logic [RQW-1:0] rq;
		if (adv) begin
			rq       = rside_out[3*DW+5 +: RQW];
			ratio_s5 <= ((rq <= CLAMP_RQ) || (ratio_rem > rq)) ? RATIO_MAX
				: ratio_quo[RTW-1:0];
			car_s5   <= rside_out;
		end
	end

	// ---------------- s6: ratio squared ----------------
	logic           v_s6;
	logic [R2W-1:0] r2_s6;
	logic [RTW-1:0] ratio_s6;
	logic [RSW-1:0] car_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		logic [2*RTW-1:0] p;
		if (adv) begin
			p        = (2*RTW)'(ratio_s5) * (2*RTW)'(ratio_s5);
			r2_s6    <= p[F +: R2W];
			ratio_s6 <= ratio_s5;
			car_s6   <= car_s5;
		end
	end

	// ---------------- s7: ratio cubed, cap at 3.0 ----------------
	logic            v_s7;
	logic [R6CW-1:0] r6_s7;
	logic            cap_s7;
	logic [RSW-1:0]  car_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		logic [R2W+RTW-1:0] p;
		logic [R6W-1:0]     r6;
		if (adv) begin
			p      = (R2W+RTW)'(r2_s6) * (R2W+RTW)'(ratio_s6);
			r6     = p[F +: R6W];
			cap_s7 <= (r6 > R6_CAP);
			r6_s7  <= (r6 > R6_CAP) ? R6_CAP[R6CW-1:0] : r6[R6CW-1:0];
			car_s7 <= car_s6;
		end
	end

	// ---------------- s8: t = r6^2 - r6, status ----------------
	logic           v_s8;
	logic [TW-1:0]  tmag_s8;
	logic           tneg_s8;
	logic [1:0]     status_s8;
	logic           zero_s8;
	logic [RSW-1:0] car_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		logic [2*R6CW-1:0] p;
		logic [SW-1:0]     s;
		logic [SW:0]       t;
		logic              far;
		logic              coin;
		if (adv) begin
			p       = (2*R6CW)'(r6_s7) * (2*R6CW)'(r6_s7);
			s       = p[F +: SW];
			t       = (SW+1)'(s) - (SW+1)'(r6_s7);
			far     = car_s7[3*DW+4];
			coin    = car_s7[3*DW+3];
			tneg_s8 <= t[SW];
			tmag_s8 <= t[SW] ? TW'(-t) : TW'(t);
			zero_s8 <= far || coin;
			priority if (far) begin
				status_s8 <= ljpf_pkg::ST_BEYOND;
			end else if (coin) begin
				status_s8 <= ljpf_pkg::ST_COINCIDENT;
			end else if (cap_s7) begin
				status_s8 <= ljpf_pkg::ST_CAPPED;
			end else begin
				status_s8 <= ljpf_pkg::ST_APPLIED;
			end
			car_s8  <= car_s7;
		end
	end

	// ---------------- s9: eps * |t| ----------------
	logic           v_s9;
	logic [EW-1:0]  e_s9;
	logic [CSW-1:0] cside_s9;
	logic [RQW-1:0] rq_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s9     <= EW'(eps_q) * EW'(tmag_s8);
			rq_s9    <= car_s8[3*DW+5 +: RQW];
			cside_s9 <= {status_s8, zero_s8, tneg_s8, car_s8[3*DW+3-1:0]};
		end
	end

	// ---------------- s10: times 12 ----------------
	logic           v_s10;
	logic [NW-1:0]  n_s10;
	logic [CSW-1:0] cside_s10;
	logic [RQW-1:0] rq_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s10     <= (NW'(e_s9) << 3) + (NW'(e_s9) << 2);
			rq_s10    <= rq_s9;
			cside_s10 <= cside_s9;
		end
	end

	// ---------------- coefficient = 12 eps |t| / rr ----------------
	logic           v_cd;
	logic [NW-1:0]  cmag;
	logic [RQW-1:0] crem;
	logic [CSW-1:0] cside;

	ljpf_div #(
		.NUM_W  (NW),
		.DEN_W  (RQW),
		.SIDE_W (CSW)
	) u_coeff (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s10),
		.num       (n_s10),
		.den       (rq_s10),
		.side_in   (cside_s10),
		.out_valid (v_cd),
		.quo       (cmag),
		.rem       (crem),
		.side_out  (cside)
	);

	// ---------------- s11: partial products of coeff * d ----------------
	logic             v_s11;
	logic [H+DW-1:0]  pl_s11  [3];
	logic [HW+DW-1:0] ph_s11  [3];
	logic             neg_s11 [3];
	logic [1:0]       status_s11;
	logic             zero_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s11 <= v_cd;
		end
	end

	always_ff @(posedge clk) begin
		logic [DW-1:0] dm;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dm          = cside[i*DW +: DW];
				pl_s11[i]   <= (H+DW)'(cmag[H-1:0]) * (H+DW)'(dm);
				ph_s11[i]   <= (HW+DW)'(cmag[NW-1:H]) * (HW+DW)'(dm);
				neg_s11[i]  <= cside[3*DW+3] ^ cside[3*DW+i];
			end
			status_s11 <= cside[3*DW+5 +: 2];
			// the remainder is unused; fold it in as a harmless zero term
			zero_s11   <= cside[3*DW+4] || (crem != crem);
		end
	end

	// ---------------- s12: full product ----------------
	logic          v_s12;
	logic [PW-1:0] prod_s12 [3];
	logic          neg_s12  [3];
	logic [1:0]    status_s12;
	logic          zero_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				prod_s12[i] <= PW'(pl_s11[i]) + (PW'(ph_s11[i]) << H);
				neg_s12[i]  <= neg_s11[i];
			end
			status_s12 <= status_s11;
			zero_s12   <= zero_s11;
		end
	end

	// ---------------- output register: scale, saturate, sign ----------------
	logic [CW-1:0] force_q [3];
	logic [1:0]    status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		logic        big;
		logic [63:0] sh;
		logic [63:0] lim;
		logic [63:0] mag;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				// a product past 64 bits saturates outright
				big = |prod_s12[i][PW-1:64];
				sh  = 64'(prod_s12[i][63:F]);
				lim = neg_s12[i] ? NEG_LIM : POS_LIM;
				mag = (big || (sh > lim)) ? lim : sh;
				if (zero_s12) begin
					force_q[i] <= '0;
				end else if (neg_s12[i]) begin
					force_q[i] <= CW'(-mag[CW-1:0]);
				end else begin
					force_q[i] <= mag[CW-1:0];
				end
			end
			status_q <= status_s12;
		end
	end

	assign rsp.force_x     = force_q[0];
	assign rsp.force_y     = force_q[1];
	assign rsp.force_z     = force_q[2];
	assign rsp.pair_status = ljpf_pkg::pair_status_t'(status_q);

endmodule

[src/ljpf_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
module ljpf_div #(
	parameter int NUM_W  = 8,
	parameter int DEN_W  = 8,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [DEN_W-1:0]  rem,
	output logic [SIDE_W-1:0] side_out
);

	logic              valid_s [NUM_W];
	logic [DEN_W-1:0]  part_s  [NUM_W];
	logic [NUM_W-1:0]  work_s  [NUM_W];
	logic [DEN_W-1:0]  den_s   [NUM_W];
	logic [SIDE_W-1:0] side_s  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic              v_in;
		logic [DEN_W-1:0]  part_in;
		logic [NUM_W-1:0]  work_in;
		logic [DEN_W-1:0]  den_in;
		logic [SIDE_W-1:0] side_k;
		logic [DEN_W:0]    trial;
		logic              take;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign part_in = '0;
			assign work_in = num;
			assign den_in  = den;
			assign side_k  = side_in;
		end else begin : g_next
			assign v_in    = valid_s[k-1];
			assign part_in = part_s[k-1];
			assign work_in = work_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_k  = side_s[k-1];
		end

		// shift in the next dividend bit, subtract when the divisor fits
		assign trial = {part_in, work_in[NUM_W-1]};
		assign take  = (trial >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				part_s[k] <= take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
				work_s[k] <= {work_in[NUM_W-2:0], take};
				den_s[k]  <= den_in;
				side_s[k] <= side_k;
			end
		end
	end

	assign out_valid = valid_s[NUM_W-1];
	assign quo       = work_s[NUM_W-1];
	assign rem       = part_s[NUM_W-1];
	assign side_out  = side_s[NUM_W-1];

endmodule

[tb/lennard_jones_pair_force_tb.sv]
// Self-checking testbench of the Lennard-Jones pair force unit.
`timescale 1ns / 1ps
module lennard_jones_pair_force_tb;

	localparam int  PIPE_DRAIN  = 160;      // drain wait, with margin beyond the pipeline depth
	localparam int  CYCLE_LIMIT = 600000;
	localparam longint ONE_Q    = 64'd1 << ljpf_pkg::FRAC_W;

	logic                          clk;
	logic                          arst_n;
	logic                          req_valid;
	logic                          req_ready;
	ljpf_pkg::pair_in_t            req;
	logic                          rsp_valid;
	logic                          rsp_ready;
	ljpf_pkg::pair_out_t           rsp;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [ljpf_pkg::APB_AW-1:0]   paddr;
	logic [ljpf_pkg::APB_DW-1:0]   pwdata;
	logic [ljpf_pkg::APB_DW-1:0]   prdata;
	logic                          pready;

	// Shadow copy of the register file, used by the force predictor.
	logic [ljpf_pkg::REG_W-1:0]    box_shadow;
	logic [ljpf_pkg::REG_W-1:0]    eps_shadow;

	ljpf_pkg::pair_in_t            pending_pairs[$];
	ljpf_pkg::pair_out_t           expected_forces[$];
	int                            send_idle_pct;
	int                            stall_pct;
	int                            error_count;
	int                            cycle_count;

	lennard_jones_pair_force dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Minimum-image fold of one axis: returns |d'|, sign through neg.
	function automatic longint unsigned fold_axis(longint signed a, longint signed b,
			longint unsigned len, output bit neg);
		longint signed   d;
		longint unsigned m;
		longint unsigned q;
		longint signed   r;
		d   = a - b;
		m   = (d < 0) ? longint'(-d) : longint'(d);
		q   = (2 * m + len) / (2 * len);
		r   = longint'(m) - longint'(q * len);
		neg = (d < 0);
		if (r < 0) begin
			neg = !neg;
			r   = -r;
		end
		return longint'(r);
	endfunction

	// Expected force on bead a for one pair, under the current register shadow.
	function automatic ljpf_pkg::pair_out_t predict_pair_force(ljpf_pkg::pair_in_t p);
		longint signed   pa[3];
		longint signed   pb[3];
		longint unsigned dmag[3];
		bit              dneg[3];
		longint unsigned len, rr2, rq, ratio, r2, r6, tmag, cmag, mag, lim;
		longint signed   t;
		bit              tneg, neg;
		ljpf_pkg::pair_out_t o;
		logic [ljpf_pkg::COORD_W-1:0] f[3];
		pa[0] = p.pos_a_x; pa[1] = p.pos_a_y; pa[2] = p.pos_a_z;
		pb[0] = p.pos_b_x; pb[1] = p.pos_b_y; pb[2] = p.pos_b_z;
		len = (box_shadow == 0) ? 64'd1 : longint'(box_shadow);
		rr2 = 0;
		for (int i = 0; i < 3; i++) begin
			dmag[i] = fold_axis(pa[i], pb[i], len, dneg[i]);
			rr2 += dmag[i] * dmag[i];
		end
		o = '0;
		if (rr2 >= (64'd25 << (2 * ljpf_pkg::FRAC_W))) begin
			o.pair_status = ljpf_pkg::ST_BEYOND;
			return o;
		end
		if (rr2 == 0) begin
			o.pair_status = ljpf_pkg::ST_COINCIDENT;
			return o;
		end
		o.pair_status = ljpf_pkg::ST_APPLIED;
		rq = rr2 >> ljpf_pkg::FRAC_W;
		if (rq == 0)
			rq = 1;
		ratio = (64'd4 << (2 * ljpf_pkg::FRAC_W)) / rq;
		if (ratio > 2 * ONE_Q)
			ratio = 2 * ONE_Q;
		r2 = (ratio * ratio) >> ljpf_pkg::FRAC_W;
		r6 = (r2 * ratio) >> ljpf_pkg::FRAC_W;
		if (r6 > 3 * ONE_Q) begin
			r6 = 3 * ONE_Q;
			o.pair_status = ljpf_pkg::ST_CAPPED;
		end
		t    = longint'((r6 * r6) >> ljpf_pkg::FRAC_W) - longint'(r6);
		tneg = (t < 0);
		tmag = tneg ? longint'(-t) : longint'(t);
		cmag = (64'd12 * longint'(eps_shadow) * tmag) / rq;
		for (int i = 0; i < 3; i++) begin
			neg = (tneg != dneg[i]);
			lim = neg ? (64'd1 << (ljpf_pkg::COORD_W - 1))
				: ((64'd1 << (ljpf_pkg::COORD_W - 1)) - 1);
			if (cmag != 0 && dmag[i] > 64'hFFFF_FFFF_FFFF_FFFF / cmag)
				mag = lim;
			else begin
				mag = (cmag * dmag[i]) >> ljpf_pkg::FRAC_W;
				if (mag > lim)
					mag = lim;
			end
			f[i] = neg ? ljpf_pkg::COORD_W'(-mag) : ljpf_pkg::COORD_W'(mag);
		end
		o.force_x = f[0];
		o.force_y = f[1];
		o.force_z = f[2];
		return o;
	endfunction

	// Driver: present pending pairs, idle at random, hold payload until the transfer.
	always @(posedge clk or negedge arst_n) begin
		bit fire;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			fire = req_valid && req_ready;
			if (fire) begin
				expected_forces.push_back(predict_pair_force(req));
				void'(pending_pairs.pop_front());
			end
			if (!req_valid || fire) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req       <= pending_pairs[0];
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, compare each transfer against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		ljpf_pkg::pair_out_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_forces.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result %h", $time, rsp);
				end else begin
					want = expected_forces.pop_front();
					if (rsp.force_x !== want.force_x || rsp.force_y !== want.force_y ||
					    rsp.force_z !== want.force_z ||
					    rsp.pair_status !== want.pair_status) begin
						error_count++;
						$display("%0t: force mismatch expected %h %h %h %s got %h %h %h %0d",
						         $time, want.force_x, want.force_y, want.force_z,
						         want.pair_status.name(), rsp.force_x, rsp.force_y,
						         rsp.force_z, rsp.pair_status);
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Write one register through the APB port: setup cycle, then access cycle.
	task automatic write_reg(ljpf_pkg::reg_idx_t idx, logic [ljpf_pkg::REG_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == ljpf_pkg::REG_BOX_LENGTH)
			box_shadow = value;
		else
			eps_shadow = value;
	endtask

	// Block until every pair is sent, every result is back and the pipe has drained.
	task automatic drain_pipe();
		while (pending_pairs.size() != 0 || req_valid || expected_forces.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	function automatic ljpf_pkg::pair_in_t make_pair(longint signed ax, longint signed ay,
			longint signed az, longint signed bx, longint signed by, longint signed bz);
		ljpf_pkg::pair_in_t p;
		p.pos_a_x = ljpf_pkg::COORD_W'(ax);
		p.pos_a_y = ljpf_pkg::COORD_W'(ay);
		p.pos_a_z = ljpf_pkg::COORD_W'(az);
		p.pos_b_x = ljpf_pkg::COORD_W'(bx);
		p.pos_b_y = ljpf_pkg::COORD_W'(by);
		p.pos_b_z = ljpf_pkg::COORD_W'(bz);
		return p;
	endfunction

	// Random pair: mostly beads within a few units, sometimes shifted by whole boxes.
	function automatic ljpf_pkg::pair_in_t random_pair();
		longint signed a[3];
		longint signed b[3];
		longint signed span;
		int            kind;
		kind = $urandom_range(99);
		span = (kind < 40) ? 3 * ONE_Q : 7 * ONE_Q;
		for (int i = 0; i < 3; i++) begin
			a[i] = longint'(int'($urandom));
			if (kind < 85) begin
				b[i] = a[i] + longint'($urandom_range(2 * span)) - span;
				if ($urandom_range(3) == 0)
					b[i] += (longint'($urandom_range(6)) - 3) * longint'(box_shadow);
			end else begin
				b[i] = longint'(int'($urandom));
			end
		end
		return make_pair(a[0], a[1], a[2], b[0], b[1], b[2]);
	endfunction

	initial begin
		logic [ljpf_pkg::REG_W-1:0] box_set[5];
		logic [ljpf_pkg::REG_W-1:0] eps_set[5];
		longint signed              hi, lo;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		error_count   = 0;
		cycle_count   = 0;
		box_shadow    = ljpf_pkg::BOX_RESET;
		eps_shadow    = ljpf_pkg::EPS_RESET;
		hi            = 64'sh7FFF_FFFF;
		lo            = -64'sh8000_0000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs under the reset register values, no idling.
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));                    // coincident
		pending_pairs.push_back(make_pair(hi, lo, hi, hi, lo, hi));              // coincident at extremes
		pending_pairs.push_back(make_pair(5 * ONE_Q, 0, 0, 0, 0, 0));            // exactly on cutoff
		pending_pairs.push_back(make_pair(6 * ONE_Q, 0, 0, 0, 0, 0));            // beyond cutoff
		pending_pairs.push_back(make_pair(ONE_Q, 0, 0, 0, 0, 0));                // capped
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 1));                    // tiny distance
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 1, 1));                    // below one lsb of rr
		pending_pairs.push_back(make_pair(2 * ONE_Q, 0, 0, 0, 0, 0));            // applied, r6 small
		pending_pairs.push_back(make_pair(ONE_Q + ONE_Q / 2, ONE_Q / 3, 0, 0, 0, 0));
		pending_pairs.push_back(make_pair(0, -2 * ONE_Q, ONE_Q, 0, 0, 0));       // negative axes
		pending_pairs.push_back(make_pair(19 * ONE_Q, 0, 0, 0, 0, 0));           // wraps to -1
		pending_pairs.push_back(make_pair(10 * ONE_Q, 0, 0, 0, 0, 0));           // half box tie
		pending_pairs.push_back(make_pair(hi, hi, hi, lo, lo, lo));              // widest span
		pending_pairs.push_back(make_pair(lo, lo, lo, hi, hi, hi));
		pending_pairs.push_back(make_pair(hi, 0, lo, 0, hi, 0));                 // outside box
		pending_pairs.push_back(make_pair(-1, -1, -1, 0, 0, 0));
		pending_pairs.push_back(make_pair(3 * ONE_Q, 3 * ONE_Q, 3 * ONE_Q, 0, 0, 0));
		drain_pipe();

		// Large well depth with a small displacement drives the forces into saturation.
		write_reg(ljpf_pkg::REG_WELL_DEPTH, {ljpf_pkg::REG_W{1'b1}});
		pending_pairs.push_back(make_pair(ONE_Q, -ONE_Q, ONE_Q / 2, 0, 0, 0));
		pending_pairs.push_back(make_pair(ONE_Q + ONE_Q / 2, ONE_Q, -ONE_Q, 0, 0, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 2 * ONE_Q, -ONE_Q, 0));
		drain_pipe();

		// Random phases: one register setting and one idling pattern each.
		box_set = '{ljpf_pkg::BOX_RESET, ljpf_pkg::REG_W'(ONE_Q), {ljpf_pkg::REG_W{1'b1}},
		            ljpf_pkg::REG_W'(7 * ONE_Q + 12345), ljpf_pkg::REG_W'(40 * ONE_Q)};
		eps_set = '{ljpf_pkg::EPS_RESET, '0, {ljpf_pkg::REG_W{1'b1}},
		            ljpf_pkg::REG_W'(3 * ONE_Q + 777), ljpf_pkg::REG_W'(ONE_Q / 4)};
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(ljpf_pkg::REG_BOX_LENGTH, box_set[ph % 5]);
			write_reg(ljpf_pkg::REG_WELL_DEPTH, eps_set[(ph * 3) % 5]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 57; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 57; end
				default: begin send_idle_pct = 36; stall_pct = 36; end
			endcase
			for (int n = 0; n < 230; n++)
				pending_pairs.push_back(random_pair());
			drain_pipe();
		end

		send_idle_pct = 0;
		stall_pct     = 0;
		drain_pipe();
		if (error_count == 0 && expected_forces.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[files.f]
src/ljpf_pkg.sv
src/ljpf_div.sv
src/lennard_jones_pair_force.sv
tb/lennard_jones_pair_force_tb.sv
